[design/igbs_pkg.sv]
// Shared constants and types for the IoU-gated box smoother.
package igbs_pkg;

	// Q0.16 fixed point
	localparam int Q_BITS  = 16;
	localparam int ONE_Q16 = 65536;

	// Register reset values
	localparam int ALPHA_RST   = 32768;
	localparam int IOU_THR_RST = 32768;
	localparam int IMG_W_RST   = 1920;
	localparam int IMG_H_RST   = 1080;

	// Register indexes on the config write port
	typedef enum logic [1:0] {
		REG_ALPHA   = 2'd0,
		REG_IOU_THR = 2'd1,
		REG_IMG_W   = 2'd2,
		REG_IMG_H   = 2'd3
	} igbs_reg_t;

	// Stage load enables handed to the blend unit
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} igbs_adv_t;

endpackage

[design/igbs_blend.sv]
// Three-stage blend of one corner: alpha*old + (1-alpha)*trk, truncate, saturate.
module igbs_blend import igbs_pkg::*; #(
	parameter int COORD_BITS = 14
) (
	input  logic                         clk,
	input  igbs_adv_t                    adv,
	input  logic [Q_BITS-1:0]            alpha,
	input  logic signed [COORD_BITS-1:0] old_val,
	input  logic signed [COORD_BITS:0]   trk_val,
	output logic signed [COORD_BITS-1:0] res
);

	localparam int PW = COORD_BITS + 19;
	localparam int QW = PW - Q_BITS;
	localparam logic signed [QW-1:0] QMAX = QW'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic signed [QW-1:0] QMIN = ~QMAX;

	logic [Q_BITS:0]        wb_c;
	logic signed [PW-1:0]   pa_c, pb_c;
	logic signed [PW-1:0]   pa_s2, pb_s2;
	logic signed [PW-1:0]   sum_s3;
	logic signed [PW-1:0]   adj_c;
	logic signed [QW-1:0]   quo_c;
	logic signed [COORD_BITS-1:0] sat_c;

	// Weighted products
	always_comb begin
		wb_c = (Q_BITS + 1)'(ONE_Q16) - {1'b0, alpha};
		pa_c = $signed({1'b0, alpha}) * old_val;
		pb_c = $signed({1'b0, wb_c}) * trk_val;
	end

	// Round toward zero, then clamp to the coordinate range
	always_comb begin
		adj_c = sum_s3 + (sum_s3[PW-1] ? PW'(ONE_Q16 - 1) : '0);
		quo_c = $signed(adj_c[PW-1:Q_BITS]);
		if (quo_c > QMAX) begin
			sat_c = QMAX[COORD_BITS-1:0];
		end else if (quo_c < QMIN) begin
			sat_c = QMIN[COORD_BITS-1:0];
		end else begin
			sat_c = quo_c[COORD_BITS-1:0];
		end
	end

	// Advance the blend stages
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			pa_s2 <= pa_c;
			pb_s2 <= pb_c;
		end
		if (adv.s3) begin
			sum_s3 <= pa_s2 + pb_s2;
		end
		if (adv.s4) begin
			res <= sat_c;
		end
	end

endmodule

[design/iou_gated_box_smoother_core.sv]
// Top level of the IoU-gated box smoother: six-stage pipeline and config registers.
//
// Usage: each input item holds a detected box (corners) and a tracked box
// (x, y, width, height). Items enter on in_valid/in_ready, results leave on
// out_valid/out_ready, one result per item, in order. A result carries the
// four output corners and the merged flag: set when the IoU passes the
// threshold and the tracked size is nonzero, in which case the corners are
// blended with the tracked box; otherwise the detected corners pass through.
// Throughput: one item per cycle unless out_ready stalls the output; the six
// register stages each hold an item.
// The threshold multiply (16 x 2*COORD_BITS+1 bits) sets the deepest stage.
// When out_ready is low, the output stage holds its item and earlier stages
// keep filling bubbles; in_ready falls only once all six stages are full.
// Configuration is written through cfg_wen/cfg_addr/cfg_data, by the user only
// while idle; the block does not enforce this. Reset clears all stage valid bits
// and loads the register defaults: alpha 0.5, threshold 0.5, image 1920 x 1080.
module iou_gated_box_smoother_core import igbs_pkg::*; #(
	parameter int COORD_BITS = 14,
	localparam int CFG_W = (COORD_BITS > Q_BITS) ? COORD_BITS : Q_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write port
	input  logic                         cfg_wen,
	input  logic [1:0]                   cfg_addr,
	input  logic [CFG_W-1:0]             cfg_data,
	// input items
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] obj_left,
	input  logic signed [COORD_BITS-1:0] obj_top,
	input  logic signed [COORD_BITS-1:0] obj_right,
	input  logic signed [COORD_BITS-1:0] obj_bottom,
	input  logic signed [COORD_BITS-1:0] trk_x,
	input  logic signed [COORD_BITS-1:0] trk_y,
	input  logic [COORD_BITS-2:0]        trk_width,
	input  logic [COORD_BITS-2:0]        trk_height,
	// result items
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_left,
	output logic signed [COORD_BITS-1:0] out_top,
	output logic signed [COORD_BITS-1:0] out_right,
	output logic signed [COORD_BITS-1:0] out_bottom,
	output logic                         merged
);

	localparam int C  = COORD_BITS;
	localparam int AW = 2 * C;
	localparam int TW = 2 * C - 2;
	localparam int UW = 2 * C + 1;
	localparam int PW = UW + Q_BITS;

	// Configuration registers
	logic [Q_BITS-1:0] alpha_q, thr_q;
	logic [C-1:0]      img_w_q, img_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= Q_BITS'(ALPHA_RST);
			thr_q   <= Q_BITS'(IOU_THR_RST);
			img_w_q <= C'(IMG_W_RST);
			img_h_q <= C'(IMG_H_RST);
		end else if (cfg_wen) begin
			case (igbs_reg_t'(cfg_addr))
				REG_ALPHA:   alpha_q <= cfg_data[Q_BITS-1:0];
				REG_IOU_THR: thr_q   <= cfg_data[Q_BITS-1:0];
				REG_IMG_W:   img_w_q <= cfg_data[C-1:0];
				REG_IMG_H:   img_h_q <= cfg_data[C-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and enables: a stage loads when it is empty or the next one moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	igbs_adv_t adv;

	always_comb begin
		en6 = !v_s6 || out_ready;
		en5 = !v_s5 || en6;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		adv.s2 = en2;
		adv.s3 = en3;
		adv.s4 = en4;
	end

	assign in_ready  = en1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: spans, edge positions and clamped tracked lower-right corner
	logic signed [C:0] l_x, t_x, r_x, b_x, tx_x, ty_x, dif_w, dif_h;
	logic [C-1:0]      dw_c, dh_c;
	logic signed [C:0] le_c, te_c, tre_c, tbe_c, lrx_c, lry_c, imw_x, imh_x;

	always_comb begin
		l_x   = (C + 1)'(obj_left);
		t_x   = (C + 1)'(obj_top);
		r_x   = (C + 1)'(obj_right);
		b_x   = (C + 1)'(obj_bottom);
		tx_x  = (C + 1)'(trk_x);
		ty_x  = (C + 1)'(trk_y);
		dif_w = r_x - l_x;
		dif_h = b_x - t_x;
		dw_c  = (dif_w > 0) ? dif_w[C-1:0] : C'(1);
		dh_c  = (dif_h > 0) ? dif_h[C-1:0] : C'(1);
		le_c  = l_x + $signed({1'b0, dw_c});
		te_c  = t_x + $signed({1'b0, dh_c});
		tre_c = tx_x + $signed({2'b00, trk_width});
		tbe_c = ty_x + $signed({2'b00, trk_height});
		imw_x = $signed({1'b0, img_w_q});
		imh_x = $signed({1'b0, img_h_q});
		lrx_c = (tre_c < imw_x) ? tre_c : imw_x - (C + 1)'(1);
		lry_c = (tbe_c < imh_x) ? tbe_c : imh_x - (C + 1)'(1);
	end

	logic signed [C-1:0] l_s1, t_s1, r_s1, b_s1, tx_s1, ty_s1;
	logic [C-2:0]        tw_s1, th_s1;
	logic [C-1:0]        dw_s1, dh_s1;
	logic signed [C:0]   le_s1, te_s1, tre_s1, tbe_s1, lrx_s1, lry_s1;
	logic                ok_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			l_s1   <= obj_left;
			t_s1   <= obj_top;
			r_s1   <= obj_right;
			b_s1   <= obj_bottom;
			tx_s1  <= trk_x;
			ty_s1  <= trk_y;
			tw_s1  <= trk_width;
			th_s1  <= trk_height;
			dw_s1  <= dw_c;
			dh_s1  <= dh_c;
			le_s1  <= le_c;
			te_s1  <= te_c;
			tre_s1 <= tre_c;
			tbe_s1 <= tbe_c;
			lrx_s1 <= lrx_c;
			lry_s1 <= lry_c;
			ok_s1  <= (trk_width != '0) && (trk_height != '0);
		end
	end

	// Stage 2: overlap spans, clipped at zero, and box areas
	logic signed [C:0]   mn_w, mn_h;
	logic signed [C-1:0] mx_w, mx_h;
	logic signed [C+1:0] iw_raw, ih_raw;
	logic [C-2:0]        iw_c, ih_c;
	logic [AW-1:0]       area_d_c;
	logic [TW-1:0]       area_t_c;

	always_comb begin
		mn_w     = (le_s1 < tre_s1) ? le_s1 : tre_s1;
		mn_h     = (te_s1 < tbe_s1) ? te_s1 : tbe_s1;
		mx_w     = (l_s1 > tx_s1) ? l_s1 : tx_s1;
		mx_h     = (t_s1 > ty_s1) ? t_s1 : ty_s1;
		iw_raw   = (C + 2)'(mn_w) - (C + 2)'(mx_w);
		ih_raw   = (C + 2)'(mn_h) - (C + 2)'(mx_h);
		iw_c     = iw_raw[C+1] ? '0 : iw_raw[C-2:0];
		ih_c     = ih_raw[C+1] ? '0 : ih_raw[C-2:0];
		area_d_c = dw_s1 * dh_s1;
		area_t_c = tw_s1 * th_s1;
	end

	logic signed [C-1:0] l_s2, t_s2, r_s2, b_s2;
	logic [C-2:0]        iw_s2, ih_s2;
	logic [AW-1:0]       area_d_s2;
	logic [TW-1:0]       area_t_s2;
	logic                ok_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			l_s2      <= l_s1;
			t_s2      <= t_s1;
			r_s2      <= r_s1;
			b_s2      <= b_s1;
			iw_s2     <= iw_c;
			ih_s2     <= ih_c;
			area_d_s2 <= area_d_c;
			area_t_s2 <= area_t_c;
			ok_s2     <= ok_s1;
		end
	end

	// Stage 3: intersection area and area sum
	logic signed [C-1:0] l_s3, t_s3, r_s3, b_s3;
	logic [TW-1:0]       inter_s3;
	logic [UW-1:0]       sum_s3;
	logic                ok_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			l_s3     <= l_s2;
			t_s3     <= t_s2;
			r_s3     <= r_s2;
			b_s3     <= b_s2;
			inter_s3 <= iw_s2 * ih_s2;
			sum_s3   <= UW'(area_d_s2) + UW'(area_t_s2);
			ok_s3    <= ok_s2;
		end
	end

	// Stage 4: union area
	logic signed [C-1:0] l_s4, t_s4, r_s4, b_s4;
	logic [TW-1:0]       inter_s4;
	logic [UW-1:0]       uni_s4;
	logic                ok_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			l_s4     <= l_s3;
			t_s4     <= t_s3;
			r_s4     <= r_s3;
			b_s4     <= b_s3;
			inter_s4 <= inter_s3;
			uni_s4   <= sum_s3 - UW'(inter_s3);
			ok_s4    <= ok_s3;
		end
	end

	// Blend units, results aligned with stage 4
	logic signed [C:0]   old_l_x, old_t_x;
	logic signed [C-1:0] bl_l, bl_t, bl_r, bl_b;

	assign old_l_x = (C + 1)'(tx_s1);
	assign old_t_x = (C + 1)'(ty_s1);

	igbs_blend #(.COORD_BITS(C)) u_blend_l (
		.clk(clk), .adv(adv), .alpha(alpha_q),
		.old_val(l_s1), .trk_val(old_l_x), .res(bl_l)
	);
	igbs_blend #(.COORD_BITS(C)) u_blend_t (
		.clk(clk), .adv(adv), .alpha(alpha_q),
		.old_val(t_s1), .trk_val(old_t_x), .res(bl_t)
	);
	igbs_blend #(.COORD_BITS(C)) u_blend_r (
		.clk(clk), .adv(adv), .alpha(alpha_q),
		.old_val(r_s1), .trk_val(lrx_s1), .res(bl_r)
	);
	igbs_blend #(.COORD_BITS(C)) u_blend_b (
		.clk(clk), .adv(adv), .alpha(alpha_q),
		.old_val(b_s1), .trk_val(lry_s1), .res(bl_b)
	);

	// Stage 5: threshold times union
	logic signed [C-1:0] l_s5, t_s5, r_s5, b_s5;
	logic signed [C-1:0] bl_l_s5, bl_t_s5, bl_r_s5, bl_b_s5;
	logic [TW-1:0]       inter_s5;
	logic [PW-1:0]       prod_s5;
	logic                uni_nz_s5, ok_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			l_s5      <= l_s4;
			t_s5      <= t_s4;
			r_s5      <= r_s4;
			b_s5      <= b_s4;
			bl_l_s5   <= bl_l;
			bl_t_s5   <= bl_t;
			bl_r_s5   <= bl_r;
			bl_b_s5   <= bl_b;
			inter_s5  <= inter_s4;
			prod_s5   <= thr_q * uni_s4;
			uni_nz_s5 <= (uni_s4 != '0);
			ok_s5     <= ok_s4;
		end
	end

	// Stage 6: threshold test and output select
	logic pass_c, merge_c;

	always_comb begin
		pass_c  = uni_nz_s5 && (PW'({inter_s5, {Q_BITS{1'b0}}}) > prod_s5);
		merge_c = pass_c && ok_s5;
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			out_left   <= merge_c ? bl_l_s5 : l_s5;
			out_top    <= merge_c ? bl_t_s5 : t_s5;
			out_right  <= merge_c ? bl_r_s5 : r_s5;
			out_bottom <= merge_c ? bl_b_s5 : b_s5;
			merged     <= merge_c;
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted item lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item missing from stage 1");

	// Any empty stage lets a new item in
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || !v_s2 || !v_s3 || !v_s4 || !v_s5 || !v_s6) |-> in_ready)
		else $error("input stalled while a stage is empty");

	// A full pipeline under output stall blocks the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !out_ready |-> !in_ready)
		else $error("input accepted into a full stalled pipeline");

	// An item in stage 5 moves into an empty output stage
	a_fill_output: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !v_s6 |=> v_s6)
		else $error("item did not advance into empty output stage");
`endif

endmodule
